@@ hw/rtl/apma_pkg.sv @@
// Package for the AC power meter accumulator: widths, reset constants, types.
// No dependencies; used by every other file of the block.
package apma_pkg;
	localparam int unsigned NUM_CURRENTS_DEF = 4;
	localparam int unsigned ACC_WIDTH_DEF = 40;
	localparam int unsigned SAMPLE_W = 10;
	localparam int unsigned SUM_W = 40;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned COEF_W = 9;
	localparam int unsigned CPW_W = 8;
	localparam int unsigned CENT_W = 20;
	localparam int unsigned HALF_W = 32;
	localparam int unsigned VS_W = 18;
	localparam logic signed [CENT_W-1:0] OFFSET_RESET = 20'sd130560;
	localparam logic signed [CENT_W-1:0] OFFSET_MAX = 20'sd261888;
	localparam logic signed [VS_W-1:0] PREV_RESET = 18'sd14080;
	localparam logic [CPW_W-1:0] CPW_RESET = 8'd50;
	localparam logic [COEF_W-1:0] COEF_RESET = 9'd256;
	localparam int unsigned PADDR_W = 5;

	localparam logic [PADDR_W-1:0] ADDR_CPW = 5'h00;
	localparam logic [PADDR_W-1:0] ADDR_COEF0 = 5'h04;
	localparam logic [PADDR_W-1:0] ADDR_COEF1 = 5'h08;
	localparam logic [PADDR_W-1:0] ADDR_COEF2 = 5'h0C;
	localparam logic [PADDR_W-1:0] ADDR_COEF3 = 5'h10;

	// Event decided by the front part for one sample set.
	typedef enum logic [1:0] {EV_NONE, EV_RISE, EV_CLOSE, EV_FALL} event_t;

	typedef struct packed {
		event_t ev;
		logic [SAMPLE_W-1:0] raw_v;
		logic [3:0][SAMPLE_W-1:0] raw_c;
	} job_t;

	typedef struct packed {
		logic [1:0] channel;
		logic [SUM_W-1:0] sum_voltage_sq;
		logic [SUM_W-1:0] sum_current_sq;
		logic signed [SUM_W-1:0] sum_product;
		logic [COUNT_W-1:0] sample_count;
		logic last;
	} result_t;
endpackage

@@ hw/rtl/apma_if.sv @@
// Valid/ready channel interfaces for sample sets and window results.
// Depends on apma_pkg.
interface apma_in_if;
	import apma_pkg::*;
	logic valid;
	logic ready;
	logic [SAMPLE_W-1:0] voltage_sample;
	logic [SAMPLE_W-1:0] current_sample_0;
	logic [SAMPLE_W-1:0] current_sample_1;
	logic [SAMPLE_W-1:0] current_sample_2;
	logic [SAMPLE_W-1:0] current_sample_3;
	modport source (output valid, voltage_sample, current_sample_0, current_sample_1,
		current_sample_2, current_sample_3, input ready);
	modport sink (input valid, voltage_sample, current_sample_0, current_sample_1,
		current_sample_2, current_sample_3, output ready);
endinterface

interface apma_out_if;
	import apma_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] channel;
	logic [SUM_W-1:0] sum_voltage_sq;
	logic [SUM_W-1:0] sum_current_sq;
	logic signed [SUM_W-1:0] sum_product;
	logic [COUNT_W-1:0] sample_count;
	logic last;
	modport source (output valid, channel, sum_voltage_sq, sum_current_sq, sum_product,
		sample_count, last, input ready);
	modport sink (input valid, channel, sum_voltage_sq, sum_current_sq, sum_product,
		sample_count, last, output ready);
endinterface

@@ hw/rtl/apma_front.sv @@
// Front part: accepts sample sets, tracks polarity and window count, classifies.
// Depends on apma_pkg; the voltage offset comes from the back part.
module apma_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  apma_pkg::job_t in_job,
	input  logic signed [apma_pkg::CENT_W-1:0] v_offset,
	input  logic [apma_pkg::CPW_W-1:0] cycles_per_window,
	input  logic q_empty,
	output logic push,
	output apma_pkg::job_t push_job
);
	import apma_pkg::*;
	logic pol_q;
	logic [CPW_W-1:0] cyc_q;
	logic signed [CENT_W:0] v;
	logic [CPW_W-1:0] cyc_nx;

	// The voltage offset moves only while a falling crossing is carried out, so
	// take a new set only when the queue has drained.
	assign in_ready = q_empty;
	assign push = in_valid && in_ready;
	assign v = $signed({1'b0, in_job.raw_v, 8'd0}) - {v_offset[CENT_W-1], v_offset};
	assign cyc_nx = cyc_q + CPW_W'(1);

	always_comb begin
		push_job = in_job;
		push_job.ev = EV_NONE;
		if (!v[CENT_W] && !pol_q)
			push_job.ev = (cyc_nx == cycles_per_window) ? EV_CLOSE : EV_RISE;
		else if (v[CENT_W] && pol_q)
			push_job.ev = EV_FALL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pol_q <= 1'b0;
			cyc_q <= '0;
		end else if (push) begin
			if (push_job.ev == EV_RISE) begin
				pol_q <= 1'b1;
				cyc_q <= cyc_nx;
			end else if (push_job.ev == EV_CLOSE) begin
				pol_q <= 1'b1;
				cyc_q <= '0;
			end else if (push_job.ev == EV_FALL) begin
				pol_q <= 1'b0;
			end
		end
	end
endmodule

@@ hw/rtl/apma_queue.sv @@
// Two-entry queue of classified jobs between front and back parts.
// Depends on apma_pkg.
module apma_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  apma_pkg::job_t push_job,
	input  logic pop,
	output logic empty,
	output logic full,
	output apma_pkg::job_t head
);
	import apma_pkg::*;
	job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full = (cnt_q == 2'd2);
	assign head = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (pop && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
		end
	end
endmodule

@@ hw/rtl/apma_back.sv @@
// Back part: sequencer that updates offsets, half sums and accumulators, one
// channel at a time with a shared multiplier path, and emits window results.
// Depends on apma_pkg.
module apma_back #(
	parameter int unsigned NUM_CURRENTS = apma_pkg::NUM_CURRENTS_DEF,
	parameter int unsigned ACC_WIDTH = apma_pkg::ACC_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  apma_pkg::job_t head,
	output logic pop,
	input  logic [3:0][apma_pkg::COEF_W-1:0] coef,
	output logic signed [apma_pkg::CENT_W-1:0] v_offset,
	output logic res_valid,
	input  logic res_ready,
	output apma_pkg::result_t res
);
	import apma_pkg::*;
	localparam int unsigned CH_W = (NUM_CURRENTS > 1) ? $clog2(NUM_CURRENTS) : 1;
	localparam logic [ACC_WIDTH-1:0] UMAX = {ACC_WIDTH{1'b1}};
	localparam logic signed [ACC_WIDTH-1:0] SMAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_WIDTH-1:0] SMIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

	typedef enum logic [2:0] {ST_IDLE, ST_EMIT, ST_VOLT, ST_CUR, ST_CUR2} state_t;
	state_t state_q;
	logic [CH_W-1:0] ch_q;

	logic signed [CENT_W-1:0] voff_q;
	logic signed [CENT_W-1:0] coff_q [NUM_CURRENTS];
	logic signed [HALF_W-1:0] hv_q;
	logic signed [HALF_W-1:0] hc_q [NUM_CURRENTS];
	logic [ACC_WIDTH-1:0] avs_q;
	logic [ACC_WIDTH-1:0] acs_q [NUM_CURRENTS];
	logic signed [ACC_WIDTH-1:0] apr_q [NUM_CURRENTS];
	logic [COUNT_W-1:0] cnt_q;
	logic signed [VS_W-1:0] prev_q, vs_q;
	logic signed [VS_W-1:0] cs_s1;
	logic signed [VS_W+COEF_W+1:0] dprod_s1;

	// combinational pieces for the current channel
	logic signed [CENT_W:0] v_c, c_c;
	logic signed [VS_W-1:0] vs_c, cs_c;
	logic signed [VS_W:0] dv;
	logic signed [VS_W+COEF_W+1:0] dprod_c;
	logic signed [VS_W+1:0] pv;
	logic signed [VS_W*2+2:0] pprod;
	logic [2*VS_W-1:0] vsq, csq;

	function automatic logic signed [HALF_W-1:0] sat_half(input logic signed [HALF_W-1:0] a,
		input logic signed [CENT_W:0] b);
		logic signed [HALF_W:0] s;
		s = {a[HALF_W-1], a} + (HALF_W+1)'(b);
		if (s[HALF_W] != s[HALF_W-1]) return s[HALF_W] ? {1'b1, {(HALF_W-1){1'b0}}}
			: {1'b0, {(HALF_W-1){1'b1}}};
		return s[HALF_W-1:0];
	endfunction

	function automatic logic signed [CENT_W-1:0] new_off(input logic signed [CENT_W-1:0] o,
		input logic signed [HALF_W-1:0] h);
		logic signed [HALF_W:0] s;
		s = (HALF_W+1)'(o) + (HALF_W+1)'(h >>> 12);
		if (s < 0) return '0;
		if (s > (HALF_W+1)'(OFFSET_MAX)) return OFFSET_MAX;
		return s[CENT_W-1:0];
	endfunction

	function automatic logic [ACC_WIDTH-1:0] add_u(input logic [ACC_WIDTH-1:0] a,
		input logic [2*VS_W-7:0] b);
		logic [ACC_WIDTH:0] s;
		s = {1'b0, a} + (ACC_WIDTH+1)'(b);
		return s[ACC_WIDTH] ? UMAX : s[ACC_WIDTH-1:0];
	endfunction

	assign v_offset = voff_q;
	assign v_c = $signed({1'b0, head.raw_v, 8'd0}) - {voff_q[CENT_W-1], voff_q};
	assign vs_c = VS_W'(v_c >>> 2);
	assign vsq = (2*VS_W)'(vs_c * vs_c);
	assign c_c = $signed({1'b0, head.raw_c[ch_q], 8'd0}) - {coff_q[ch_q][CENT_W-1], coff_q[ch_q]};
	assign cs_c = VS_W'(c_c >>> 2);
	assign csq = (2*VS_W)'(cs_c * cs_c);
	assign dv = {vs_q[VS_W-1], vs_q} - {prev_q[VS_W-1], prev_q};
	assign dprod_c = dv * $signed({1'b0, coef[ch_q]});
	assign pv = {{2{prev_q[VS_W-1]}}, prev_q} + (VS_W+2)'(dprod_s1 >>> 8);
	assign pprod = pv * cs_s1;

	assign pop = (state_q == ST_CUR2) && (ch_q == CH_W'(NUM_CURRENTS-1));

	always_ff @(posedge clk or negedge arst_n) begin
		logic signed [2*VS_W+2:0] t;
		logic signed [ACC_WIDTH:0] ps;
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q <= '0;
			voff_q <= OFFSET_RESET;
			hv_q <= '0;
			avs_q <= '0;
			cnt_q <= '0;
			prev_q <= PREV_RESET;
			vs_q <= '0;
			cs_s1 <= '0;
			dprod_s1 <= '0;
			res_valid <= 1'b0;
			res <= '0;
			for (int i = 0; i < NUM_CURRENTS; i++) begin
				coff_q[i] <= OFFSET_RESET;
				hc_q[i] <= '0;
				acs_q[i] <= '0;
				apr_q[i] <= '0;
			end
		end else begin
			if (res_valid && res_ready && state_q != ST_EMIT) res_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					ch_q <= '0;
					if (!q_empty) begin
						unique case (head.ev)
							EV_CLOSE: state_q <= ST_EMIT;
							default: state_q <= ST_VOLT;
						endcase
					end
				end
				ST_EMIT: begin
					// hand out one channel per request, then clear that channel
					if (!res_valid || res_ready) begin
						res_valid <= 1'b1;
						res.channel <= 2'(ch_q);
						res.sum_voltage_sq <= SUM_W'(avs_q);
						res.sum_current_sq <= SUM_W'(acs_q[ch_q]);
						res.sum_product <= SUM_W'(apr_q[ch_q]);
						res.sample_count <= cnt_q;
						res.last <= (ch_q == CH_W'(NUM_CURRENTS-1));
						acs_q[ch_q] <= '0;
						apr_q[ch_q] <= '0;
						if (ch_q == CH_W'(NUM_CURRENTS-1)) begin
							avs_q <= '0;
							cnt_q <= '0;
							ch_q <= '0;
							state_q <= ST_VOLT;
						end else ch_q <= ch_q + CH_W'(1);
					end
				end
				ST_VOLT: begin
					// on a falling crossing, centre with the old offset, then move it
					// and restart the half sum from this sample
					if (head.ev == EV_FALL) begin
						voff_q <= new_off(voff_q, hv_q);
						hv_q <= sat_half('0, v_c);
					end else hv_q <= sat_half(hv_q, v_c);
					avs_q <= add_u(avs_q, (2*VS_W-6)'(vsq >> 6));
					vs_q <= vs_c;
					if (cnt_q != {COUNT_W{1'b1}}) cnt_q <= cnt_q + COUNT_W'(1);
					state_q <= ST_CUR;
				end
				ST_CUR: begin
					if (head.ev == EV_FALL) begin
						coff_q[ch_q] <= new_off(coff_q[ch_q], hc_q[ch_q]);
						hc_q[ch_q] <= sat_half('0, c_c);
					end else hc_q[ch_q] <= sat_half(hc_q[ch_q], c_c);
					acs_q[ch_q] <= add_u(acs_q[ch_q], (2*VS_W-6)'(csq >> 6));
					cs_s1 <= cs_c;
					dprod_s1 <= dprod_c;
					state_q <= ST_CUR2;
				end
				ST_CUR2: begin
					t = pprod >>> 6;
					ps = (ACC_WIDTH+1)'(apr_q[ch_q]) + (ACC_WIDTH+1)'(t);
					if (ps > (ACC_WIDTH+1)'(SMAX)) apr_q[ch_q] <= SMAX;
					else if (ps < (ACC_WIDTH+1)'(SMIN)) apr_q[ch_q] <= SMIN;
					else apr_q[ch_q] <= ps[ACC_WIDTH-1:0];
					if (ch_q == CH_W'(NUM_CURRENTS-1)) begin
						prev_q <= vs_q;
						state_q <= ST_IDLE;
					end else begin
						ch_q <= ch_q + CH_W'(1);
						state_q <= ST_CUR;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ hw/rtl/ac_power_meter_accumulator_top.sv @@
// Top level of the AC power meter accumulator: APB registers, front, queue, back.
// Depends on apma_pkg, apma_if, apma_front, apma_queue, apma_back.
//
//  channel   dir  handshake            payload
//  samples   in   valid/ready          voltage_sample, current_sample_0..3
//  results   out  valid/ready          channel, sums, sample_count, last
//  config    in   APB psel/penable     cycles_per_window, phase_coef_0..3
//
// Sequence: the back sequencer picks up a job in ST_IDLE, handles the voltage
// in ST_VOLT, then each current in ST_CUR and then ST_CUR2 through the shared
// product path; a falling crossing adds no extra step, as the offsets move
// within the same steps. A window close first passes through ST_EMIT, which
// hands out one result per current, each waiting on the result request being
// taken.
// Reset: arst_n sets all control and accumulator registers to their reset values at once, no clearing pass.
// Stalls: a new set is taken once the job queue is empty, since the centring
// offsets it is classified against move only while the previous job is carried out.
module ac_power_meter_accumulator_top #(
	parameter int unsigned NUM_CURRENTS = apma_pkg::NUM_CURRENTS_DEF,
	parameter int unsigned ACC_WIDTH = apma_pkg::ACC_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	apma_in_if.sink samples,
	apma_out_if.source results,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [apma_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import apma_pkg::*;
	logic [CPW_W-1:0] cpw_q;
	logic [3:0][COEF_W-1:0] coef_q;
	job_t in_job, push_job, head;
	logic push, pop, q_empty, q_full;
	logic signed [CENT_W-1:0] v_offset;
	result_t res;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	// register file: hold values, take writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpw_q <= CPW_RESET;
			coef_q <= {4{COEF_RESET}};
		end else if (wr) begin
			unique case (paddr)
				ADDR_CPW: cpw_q <= pwdata[CPW_W-1:0];
				ADDR_COEF0: coef_q[0] <= pwdata[COEF_W-1:0];
				ADDR_COEF1: coef_q[1] <= pwdata[COEF_W-1:0];
				ADDR_COEF2: coef_q[2] <= pwdata[COEF_W-1:0];
				ADDR_COEF3: coef_q[3] <= pwdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			ADDR_CPW: prdata = 32'(cpw_q);
			ADDR_COEF0: prdata = 32'(coef_q[0]);
			ADDR_COEF1: prdata = 32'(coef_q[1]);
			ADDR_COEF2: prdata = 32'(coef_q[2]);
			ADDR_COEF3: prdata = 32'(coef_q[3]);
			default: prdata = '0;
		endcase
	end

	always_comb begin
		in_job.ev = EV_NONE;
		in_job.raw_v = samples.voltage_sample;
		in_job.raw_c[0] = samples.current_sample_0;
		in_job.raw_c[1] = samples.current_sample_1;
		in_job.raw_c[2] = samples.current_sample_2;
		in_job.raw_c[3] = samples.current_sample_3;
	end

	apma_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(samples.valid), .in_ready(samples.ready),
		.in_job(in_job), .v_offset(v_offset), .cycles_per_window(cpw_q),
		.q_empty(q_empty), .push(push), .push_job(push_job)
	);

	apma_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_job(push_job), .pop(pop),
		.empty(q_empty), .full(q_full), .head(head)
	);

	apma_back #(.NUM_CURRENTS(NUM_CURRENTS), .ACC_WIDTH(ACC_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .head(head), .pop(pop),
		.coef(coef_q), .v_offset(v_offset), .res_valid(results.valid),
		.res_ready(results.ready), .res(res)
	);

	assign results.channel = res.channel;
	assign results.sum_voltage_sq = res.sum_voltage_sq;
	assign results.sum_current_sq = res.sum_current_sq;
	assign results.sum_product = res.sum_product;
	assign results.sample_count = res.sample_count;
	assign results.last = res.last;

	// a set is never taken while a job is queued, so the queue never fills
	assert property (@(posedge clk) disable iff (!arst_n) !q_full)
		else $error("job queue overfilled");
	assert property (@(posedge clk) disable iff (!arst_n) push |=> !q_empty)
		else $error("accepted set not queued");
	assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.ready) |=> results.valid)
		else $error("result dropped while stalled");
endmodule
